>>> sv/swmv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swmv_pkg: shared types and constants of the majority vote filter
// Sizes of the vote window, the speed sign table, the frame record that
// travels from the front end to the vote engine, and the CSR indexes.
// ---------------------------------------------------------------------------
package swmv_pkg;

   // vote window and sign table sizes
   localparam int WINDOW_DEPTH = 5;
   localparam int SIGN_CLASSES = 11;
   localparam int TABLE_LEN    = 11;

   localparam int WIN_IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int WIN_CNT_W = $clog2(WINDOW_DEPTH + 1);

   // frame record queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // field widths
   localparam int CLASS_W = 8;
   localparam int CONF_W  = 16;
   localparam int SPEED_W = 7;
   localparam int THR_W   = 4;
   localparam int CSR_W   = 8;

   // CSR indexes and reset values
   typedef enum logic [0:0] {
      CSR_CAMERA_CLASS    = 1'b0,
      CSR_MATCH_THRESHOLD = 1'b1
   } csr_index_type;

   localparam logic [CLASS_W-1:0] CAMERA_CLASS_RST    = 8'd11;
   localparam logic [THR_W-1:0]   MATCH_THRESHOLD_RST = 4'd3;

   // speed in km/h per sign class
   localparam logic [SPEED_W-1:0] SPEED_TABLE [TABLE_LEN] = '{
      7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70,
      7'd80, 7'd90, 7'd100, 7'd110, 7'd120
   };

   // classes past the table take its last entry
   function automatic logic [SPEED_W-1:0] speed_of(input logic [CLASS_W-1:0] cls);
      logic [SPEED_W-1:0] spd;
      spd = SPEED_TABLE[TABLE_LEN-1];
      for (int k = 0; k < TABLE_LEN; k++) begin
         if (cls == CLASS_W'(k)) begin
            spd = SPEED_TABLE[k];
         end
      end
      return spd;
   endfunction

   // summary of one finished frame
   typedef struct packed {
      logic [SPEED_W-1:0] best_speed;
      logic [CONF_W-1:0]  best_conf;
      logic               cam_flag;
      logic [CONF_W-1:0]  cam_conf;
   } rec_type;

endpackage
`default_nettype wire

>>> sv/sliding_window_majority_vote_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sliding_window_majority_vote_filter_core: speed sign vote filter
// Detections go in through a queue-like push/full port, one beat per
// detection. Non-final detections produce nothing. A beat with
// req_frame_end closes the frame: its record enters a two-entry queue,
// and the vote engine writes it into the five-slot ring window and scans
// the filled slots one per cycle. When the scan ends and the result
// register is free, the result is loaded there (rsp_empty low). The engine
// votes on one record at a time, while the front end keeps taking detections.
// The result stays on the rsp_ ports until popped. While it waits, up to
// two further frame records queue up and detections keep being taken;
// req_full rises only when the record queue is full.
// CSR writes (camera class, match threshold) take effect at once. The user
// must make them while the block is idle (the block does not enforce it).
// Reset empties window, queue and frame accumulators; CSRs get reset values.
// ---------------------------------------------------------------------------
module sliding_window_majority_vote_filter_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // detection beats
   input  wire logic                           req_push,
   output      logic                           req_full,
   input  wire logic                           req_detection_present,
   input  wire logic [swmv_pkg::CLASS_W-1:0]   req_class_id,
   input  wire logic [swmv_pkg::CONF_W-1:0]    req_confidence,
   input  wire logic                           req_frame_end,
   // result beats
   output      logic                           rsp_empty,
   input  wire logic                           rsp_pop,
   output      logic [swmv_pkg::SPEED_W-1:0]   rsp_speed_limit,
   output      logic                           rsp_camera_seen,
   output      logic [swmv_pkg::CONF_W-1:0]    rsp_report_confidence,
   // register writes
   input  wire logic                           csr_wr_en,
   input  wire logic [0:0]                     csr_index,
   input  wire logic [swmv_pkg::CSR_W-1:0]     csr_wdata
);

   logic [swmv_pkg::CLASS_W-1:0] camera_class_ff;
   logic [swmv_pkg::THR_W-1:0]   match_threshold_ff;
   logic                         item_accept;
   logic                         rec_push;
   logic                         rec_pop;
   logic                         q_full;
   logic                         q_empty;
   swmv_pkg::rec_type            rec_in;
   swmv_pkg::rec_type            rec_out;

   // CSRs
   always_ff @(posedge clock) begin
      if (reset) begin
         camera_class_ff    <= swmv_pkg::CAMERA_CLASS_RST;
         match_threshold_ff <= swmv_pkg::MATCH_THRESHOLD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            swmv_pkg::CSR_CAMERA_CLASS: begin
               camera_class_ff <= csr_wdata;
            end
            swmv_pkg::CSR_MATCH_THRESHOLD: begin
               match_threshold_ff <= csr_wdata[swmv_pkg::THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_full    = q_full;
   assign item_accept = req_push && !q_full;

   swmv_front u_front (
      .clock             (clock),
      .reset             (reset),
      .item_accept       (item_accept),
      .detection_present (req_detection_present),
      .class_id          (req_class_id),
      .confidence        (req_confidence),
      .frame_end         (req_frame_end),
      .camera_class      (camera_class_ff),
      .rec_push          (rec_push),
      .rec_data          (rec_in)
   );

   swmv_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (rec_in),
      .pop       (rec_pop),
      .pop_data  (rec_out),
      .full      (q_full),
      .empty     (q_empty)
   );

   swmv_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .rec_empty             (q_empty),
      .rec_data              (rec_out),
      .rec_pop               (rec_pop),
      .match_threshold       (match_threshold_ff),
      .rsp_pop               (rsp_pop),
      .rsp_empty             (rsp_empty),
      .rsp_speed_limit       (rsp_speed_limit),
      .rsp_camera_seen       (rsp_camera_seen),
      .rsp_report_confidence (rsp_report_confidence)
   );

   // checks
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("record queue full and empty at once");

   a_pop_only_valid: assert property (@(posedge clock) disable iff (reset)
      rec_pop |-> !q_empty)
      else $error("vote engine took a record from an empty queue");

   a_speed_in_table: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_speed_limit != 7'd0)) |->
         (rsp_speed_limit == 7'd20 || rsp_speed_limit == 7'd30 ||
          rsp_speed_limit == 7'd40 || rsp_speed_limit == 7'd50 ||
          rsp_speed_limit == 7'd60 || rsp_speed_limit == 7'd70 ||
          rsp_speed_limit == 7'd80 || rsp_speed_limit == 7'd90 ||
          rsp_speed_limit == 7'd100 || rsp_speed_limit == 7'd110 ||
          rsp_speed_limit == 7'd120))
      else $error("reported speed is not a table value");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

endmodule
`default_nettype wire

>>> sv/swmv_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swmv_front: detection classifier and frame accumulator
// Takes detections, keeps the best speed sign and camera of the frame and
// pushes a frame record into the queue on the frame end beat.
// ---------------------------------------------------------------------------
module swmv_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                item_accept,
   input  wire logic                                detection_present,
   input  wire logic [swmv_pkg::CLASS_W-1:0]        class_id,
   input  wire logic [swmv_pkg::CONF_W-1:0]         confidence,
   input  wire logic                                frame_end,
   input  wire logic [swmv_pkg::CLASS_W-1:0]        camera_class,
   output      logic                                rec_push,
   output      swmv_pkg::rec_type                   rec_data
);

   logic [swmv_pkg::SPEED_W-1:0] best_speed_ff, best_speed_in;
   logic [swmv_pkg::CONF_W-1:0]  best_conf_ff,  best_conf_in;
   logic                         cam_flag_ff,   cam_flag_in;
   logic [swmv_pkg::CONF_W-1:0]  cam_conf_ff,   cam_conf_in;
   logic                         is_sign;
   logic                         is_camera;

   // classify: sign test takes priority over the camera class
   assign is_sign   = detection_present && (class_id < swmv_pkg::CLASS_W'(swmv_pkg::SIGN_CLASSES));
   assign is_camera = detection_present && !is_sign && (class_id == camera_class);

   // fold this detection into the frame state
   always_comb begin
      best_speed_in = best_speed_ff;
      best_conf_in  = best_conf_ff;
      cam_flag_in   = cam_flag_ff;
      cam_conf_in   = cam_conf_ff;
      if (is_sign && (confidence > best_conf_ff)) begin
         best_conf_in  = confidence;
         best_speed_in = swmv_pkg::speed_of(class_id);
      end
      if (is_camera) begin
         cam_flag_in = 1'b1;
         if (confidence > cam_conf_ff) begin
            cam_conf_in = confidence;
         end
      end
   end

   // record of the frame, including the closing detection
   assign rec_push            = item_accept && frame_end;
   assign rec_data.best_speed = best_speed_in;
   assign rec_data.best_conf  = best_conf_in;
   assign rec_data.cam_flag   = cam_flag_in;
   assign rec_data.cam_conf   = cam_conf_in;

   // frame accumulators, cleared when the frame closes
   always_ff @(posedge clock) begin
      if (reset || rec_push) begin
         best_speed_ff <= '0;
         best_conf_ff  <= '0;
         cam_flag_ff   <= 1'b0;
         cam_conf_ff   <= '0;
      end else if (item_accept) begin
         best_speed_ff <= best_speed_in;
         best_conf_ff  <= best_conf_in;
         cam_flag_ff   <= cam_flag_in;
         cam_conf_ff   <= cam_conf_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/swmv_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swmv_fifo: short frame record queue
// Decouples the front end from the vote engine so each can stall alone.
// ---------------------------------------------------------------------------
module swmv_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire swmv_pkg::rec_type push_data,
   input  wire logic              pop,
   output      swmv_pkg::rec_type pop_data,
   output      logic              full,
   output      logic              empty
);

   swmv_pkg::rec_type                 mem_ff [swmv_pkg::QUEUE_DEPTH];
   logic [swmv_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [swmv_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [swmv_pkg::QUEUE_CNT_W-1:0]  count_ff,  count_in;
   logic                              do_push;
   logic                              do_pop;

   assign full     = (count_ff == swmv_pkg::QUEUE_CNT_W'(swmv_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == swmv_pkg::QUEUE_PTR_W'(swmv_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == swmv_pkg::QUEUE_PTR_W'(swmv_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> sv/swmv_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swmv_back: window update and vote engine
// Writes a frame record into the ring window, scans the filled slots one a
// cycle to find the winning speed, and holds the result for the consumer.
// ---------------------------------------------------------------------------
module swmv_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              rec_empty,
   input  wire swmv_pkg::rec_type                 rec_data,
   output      logic                              rec_pop,
   input  wire logic [swmv_pkg::THR_W-1:0]        match_threshold,
   input  wire logic                              rsp_pop,
   output      logic                              rsp_empty,
   output      logic [swmv_pkg::SPEED_W-1:0]      rsp_speed_limit,
   output      logic                              rsp_camera_seen,
   output      logic [swmv_pkg::CONF_W-1:0]       rsp_report_confidence
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                         state_ff, state_in;

   // ring window
   logic [swmv_pkg::SPEED_W-1:0]      speed_win_ff [swmv_pkg::WINDOW_DEPTH];
   logic [swmv_pkg::CONF_W-1:0]       conf_win_ff  [swmv_pkg::WINDOW_DEPTH];
   logic [swmv_pkg::WIN_IDX_W-1:0]    slot_ff,   slot_in;
   logic [swmv_pkg::WIN_CNT_W-1:0]    filled_ff, filled_in;

   // scan state
   logic [swmv_pkg::WIN_IDX_W-1:0]    idx_ff,     idx_in;
   logic [swmv_pkg::WIN_CNT_W-1:0]    win_cnt_ff, win_cnt_in;
   logic [swmv_pkg::SPEED_W-1:0]      win_val_ff, win_val_in;
   logic [swmv_pkg::CONF_W-1:0]       win_conf_ff, win_conf_in;
   logic                              cam_flag_ff;
   logic [swmv_pkg::CONF_W-1:0]       cam_conf_ff;

   // result holding register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [swmv_pkg::SPEED_W-1:0]      rsp_speed_ff;
   logic                              rsp_cam_ff;
   logic [swmv_pkg::CONF_W-1:0]       rsp_conf_ff;

   logic [swmv_pkg::SPEED_W-1:0]      cand;
   logic [swmv_pkg::WIN_CNT_W-1:0]    cand_cnt;
   logic [swmv_pkg::CONF_W-1:0]       cand_conf;
   logic                              last_slot;
   logic                              confirmed;
   logic [swmv_pkg::SPEED_W-1:0]      fin_speed;
   logic [swmv_pkg::CONF_W-1:0]       fin_conf;
   logic                              load_rsp;

   // votes and best confidence for the candidate under the scan index
   assign cand = speed_win_ff[idx_ff];
   always_comb begin
      cand_cnt  = '0;
      cand_conf = '0;
      for (int i = 0; i < swmv_pkg::WINDOW_DEPTH; i++) begin
         if ((swmv_pkg::WIN_CNT_W'(i) < filled_ff) && (speed_win_ff[i] == cand)) begin
            cand_cnt = cand_cnt + 1'b1;
            if (conf_win_ff[i] > cand_conf) begin
               cand_conf = conf_win_ff[i];
            end
         end
      end
   end

   assign last_slot = ((swmv_pkg::WIN_CNT_W'(idx_ff) + 1'b1) == filled_ff);

   // final pick
   assign confirmed = (win_cnt_ff != '0) &&
                      (swmv_pkg::THR_W'(win_cnt_ff) >= match_threshold);
   assign fin_speed = confirmed ? win_val_ff  : '0;
   assign fin_conf  = (confirmed && (win_conf_ff > cam_conf_ff)) ? win_conf_ff : cam_conf_ff;
   assign load_rsp  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_pop);

   assign rec_pop   = (state_ff == ST_IDLE) && !rec_empty;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      slot_in     = slot_ff;
      filled_in   = filled_ff;
      idx_in      = idx_ff;
      win_cnt_in  = win_cnt_ff;
      win_val_in  = win_val_ff;
      win_conf_in = win_conf_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!rec_empty) begin
               slot_in = (slot_ff == swmv_pkg::WIN_IDX_W'(swmv_pkg::WINDOW_DEPTH - 1))
                         ? '0 : slot_ff + 1'b1;
               if (filled_ff != swmv_pkg::WIN_CNT_W'(swmv_pkg::WINDOW_DEPTH)) begin
                  filled_in = filled_ff + 1'b1;
               end
               idx_in      = '0;
               win_cnt_in  = '0;
               win_val_in  = '0;
               win_conf_in = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // first nonzero value with the largest count wins
            if ((cand != '0) && (cand_cnt > win_cnt_ff)) begin
               win_cnt_in  = cand_cnt;
               win_val_in  = cand;
               win_conf_in = cand_conf;
            end
            if (last_slot) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         slot_ff   <= '0;
         filled_ff <= '0;
      end else begin
         state_ff  <= state_in;
         slot_ff   <= slot_in;
         filled_ff <= filled_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      win_cnt_ff  <= win_cnt_in;
      win_val_ff  <= win_val_in;
      win_conf_ff <= win_conf_in;
   end

   // window write and camera fields of the frame under vote
   always_ff @(posedge clock) begin
      if (rec_pop) begin
         speed_win_ff[slot_ff] <= rec_data.best_speed;
         conf_win_ff[slot_ff]  <= rec_data.best_conf;
         cam_flag_ff           <= rec_data.cam_flag;
         cam_conf_ff           <= rec_data.cam_conf;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_speed_ff <= fin_speed;
         rsp_cam_ff   <= cam_flag_ff;
         rsp_conf_ff  <= fin_conf;
      end
   end

   assign rsp_empty             = !rsp_valid_ff;
   assign rsp_speed_limit       = rsp_speed_ff;
   assign rsp_camera_seen       = rsp_cam_ff;
   assign rsp_report_confidence = rsp_conf_ff;

endmodule
`default_nettype wire

>>> tb/sv/sliding_window_majority_vote_filter_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sliding_window_majority_vote_filter_core_tb: self-checking bench
// Detection beats go in through the req_ queue port. A scoreboard keeps its
// own copy of the frame accumulators, the five-slot vote window and the two
// registers. On every frame end it works out the vote the block should
// report. Each rsp_ beat is checked field by field against the oldest
// outstanding vote. A short directed run covers the corner cases. Random
// frames follow under several register settings and three idling patterns.
// ---------------------------------------------------------------------------
module sliding_window_majority_vote_filter_core_tb;
   import swmv_pkg::*;

   localparam int RANDOM_ITEMS   = 1150;
   localparam int RANDOM_CHUNKS  = 6;
   localparam int SETTLE_CYCLES  = 16;
   localparam int TAIL_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT = 4000;

   // one expected or observed result beat
   typedef struct packed {
      logic [SPEED_W-1:0] speed;
      logic               camera;
      logic [CONF_W-1:0]  conf;
   } frame_vote_type;

   // frame accumulators, vote window and outstanding votes
   class speed_vote_board;
      logic [CLASS_W-1:0] cam_class;
      logic [THR_W-1:0]   threshold;
      logic [SPEED_W-1:0] slot_speed [WINDOW_DEPTH];
      logic [CONF_W-1:0]  slot_conf [WINDOW_DEPTH];
      int                 wr_slot;
      int                 n_filled;
      logic [SPEED_W-1:0] best_speed;
      logic [CONF_W-1:0]  best_conf;
      logic               cam_flag;
      logic [CONF_W-1:0]  cam_conf;
      frame_vote_type     expected_votes [$];
      int                 mismatches;

      function new();
         cam_class  = CAMERA_CLASS_RST;
         threshold  = MATCH_THRESHOLD_RST;
         wr_slot    = 0;
         n_filled   = 0;
         best_speed = '0;
         best_conf  = '0;
         cam_flag   = 1'b0;
         cam_conf   = '0;
         mismatches = 0;
         foreach (slot_speed[i]) begin
            slot_speed[i] = '0;
            slot_conf[i]  = '0;
         end
      endfunction

      function int pending();
         return expected_votes.size();
      endfunction

      // accepted detection beat; a frame end commits and votes
      function void note_detection(input logic present, input logic [CLASS_W-1:0] cls,
                                   input logic [CONF_W-1:0] conf, input logic fend);
         int          idx;
         int          votes;
         int          top_votes;
         logic [SPEED_W-1:0] top_speed;
         logic [CONF_W-1:0]  win_conf;
         frame_vote_type want;
         if (present) begin
            // sign test first, so a camera class among the signs is a sign
            if (int'(cls) < SIGN_CLASSES) begin
               if (conf > best_conf) begin
                  idx        = (int'(cls) < TABLE_LEN - 1) ? int'(cls) : TABLE_LEN - 1;
                  best_conf  = conf;
                  best_speed = SPEED_W'(20 + 10 * idx);
               end
            end else if (cls == cam_class) begin
               cam_flag = 1'b1;
               if (conf > cam_conf) cam_conf = conf;
            end
         end
         if (!fend) return;

         slot_speed[wr_slot] = best_speed;
         slot_conf[wr_slot]  = best_conf;
         wr_slot = (wr_slot + 1) % WINDOW_DEPTH;
         if (n_filled < WINDOW_DEPTH) n_filled++;

         // first nonzero speed with the largest count, slot order
         top_votes = 0;
         top_speed = '0;
         for (int i = 0; i < n_filled; i++) begin
            if (slot_speed[i] == '0) continue;
            votes = 0;
            for (int j = 0; j < n_filled; j++) begin
               if (slot_speed[j] == slot_speed[i]) votes++;
            end
            if (votes > top_votes) begin
               top_votes = votes;
               top_speed = slot_speed[i];
            end
         end

         want.speed = '0;
         win_conf   = '0;
         if (top_votes > 0 && top_votes >= int'(threshold)) begin
            want.speed = top_speed;
            for (int j = 0; j < n_filled; j++) begin
               if (slot_speed[j] == top_speed && slot_conf[j] > win_conf)
                  win_conf = slot_conf[j];
            end
         end
         want.camera = cam_flag;
         want.conf   = (win_conf > cam_conf) ? win_conf : cam_conf;
         expected_votes.push_back(want);

         best_speed = '0;
         best_conf  = '0;
         cam_flag   = 1'b0;
         cam_conf   = '0;
      endfunction

      task report(input string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      // accepted result beat against the oldest outstanding vote
      task check_vote(input logic [SPEED_W-1:0] speed, input logic camera,
                      input logic [CONF_W-1:0] conf);
         frame_vote_type want;
         if (expected_votes.size() == 0) begin
            report($sformatf("result with none outstanding: speed=%0d cam=%0b conf=%h",
                             speed, camera, conf));
            return;
         end
         want = expected_votes.pop_front();
         if (speed !== want.speed)
            report($sformatf("speed_limit got %0d want %0d", speed, want.speed));
         if (camera !== want.camera)
            report($sformatf("camera_seen got %0b want %0b", camera, want.camera));
         if (conf !== want.conf)
            report($sformatf("report_confidence got %h want %h", conf, want.conf));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic               req_detection_present = 1'b0;
   logic [CLASS_W-1:0] req_class_id = '0;
   logic [CONF_W-1:0]  req_confidence = '0;
   logic               req_frame_end = 1'b0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [SPEED_W-1:0] rsp_speed_limit;
   logic               rsp_camera_seen;
   logic [CONF_W-1:0]  rsp_report_confidence;
   logic               csr_wr_en = 1'b0;
   logic [0:0]         csr_index = CSR_CAMERA_CLASS;
   logic [CSR_W-1:0]   csr_wdata = '0;

   speed_vote_board    board = new();
   int                 send_idle_pct = 10;
   int                 recv_idle_pct = 52;
   int                 items_sent = 0;
   int                 quiet_cycles = 0;
   logic [CLASS_W-1:0] cam_class_now = CAMERA_CLASS_RST;
   logic [CONF_W-1:0]  last_conf = '0;

   sliding_window_majority_vote_filter_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_detection_present (req_detection_present),
      .req_class_id          (req_class_id),
      .req_confidence        (req_confidence),
      .req_frame_end         (req_frame_end),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_speed_limit       (rsp_speed_limit),
      .rsp_camera_seen       (rsp_camera_seen),
      .rsp_report_confidence (rsp_report_confidence),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #6 clock = ~clock;

   // result side: check accepted beats, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         board.check_vote(rsp_speed_limit, rsp_camera_seen, rsp_report_confidence);
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog: too long without any beat on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] watchdog expired", $realtime);
         $display("** sliding_window_majority_vote_filter_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one detection beat, with a random gap ahead of it
   task automatic send_detection(input logic present, input logic [CLASS_W-1:0] cls,
                                 input logic [CONF_W-1:0] conf, input logic fend);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push              <= 1'b1;
      req_detection_present <= present;
      req_class_id          <= cls;
      req_confidence        <= conf;
      req_frame_end         <= fend;
      do @(posedge clock); while (req_full);
      board.note_detection(present, cls, conf, fend);
      items_sent++;
   endtask

   // hold off the sender until every outstanding vote is back
   task automatic wait_for_results();
      req_push <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // both registers, written while the block is idle
   task automatic program_filter(input logic [CLASS_W-1:0] cam, input logic [CSR_W-1:0] thr_word);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_CAMERA_CLASS;
      csr_wdata <= cam;
      @(posedge clock);
      board.cam_class = cam;
      csr_index <= CSR_MATCH_THRESHOLD;
      csr_wdata <= thr_word;
      @(posedge clock);
      board.threshold = thr_word[THR_W-1:0];
      csr_wr_en <= 1'b0;
      cam_class_now = cam;
      @(posedge clock);
   endtask

   // a frame of one to four beats, biased towards one sign class
   task automatic send_random_frame(input logic [CLASS_W-1:0] favourite);
      int                 n_items;
      int                 pick;
      logic               present;
      logic [CLASS_W-1:0] cls;
      logic [CONF_W-1:0]  conf;
      n_items = $urandom_range(4, 1);
      for (int k = 0; k < n_items; k++) begin
         present = ($urandom_range(99) < 88);
         pick = $urandom_range(99);
         if (pick < 55)      cls = favourite;
         else if (pick < 72) cls = CLASS_W'($urandom_range(SIGN_CLASSES - 1));
         else if (pick < 88) cls = cam_class_now;
         else                cls = CLASS_W'($urandom);
         pick = $urandom_range(99);
         if (pick < 5)       conf = '0;
         else if (pick < 10) conf = '1;
         else if (pick < 16) conf = last_conf;
         else                conf = CONF_W'($urandom);
         last_conf = conf;
         send_detection(present, cls, conf, k == n_items - 1);
      end
   endtask

   initial begin : stimulus
      int                 chunk_end;
      logic [CLASS_W-1:0] favourite;
      logic [CLASS_W-1:0] cam;
      logic [CSR_W-1:0]   thr_word;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset register values
      send_detection(1'b0, 8'hFF, 16'hFFFF, 1'b1);   // empty frame
      send_detection(1'b1, 8'd0, 16'h0000, 1'b0);    // zero-confidence sign
      send_detection(1'b0, 8'd3, 16'h1234, 1'b1);    // absent beat ends frame
      send_detection(1'b1, 8'd10, 16'hFFFF, 1'b0);
      send_detection(1'b1, 8'd3, 16'hFFFF, 1'b0);    // tie, first kept
      send_detection(1'b1, 8'd11, 16'h1234, 1'b0);
      send_detection(1'b1, 8'd11, 16'h8000, 1'b1);   // camera on the end beat
      send_detection(1'b1, 8'd10, 16'h8000, 1'b1);
      send_detection(1'b1, 8'd10, 16'h8000, 1'b1);   // third vote for 120
      send_detection(1'b1, 8'd255, 16'h7FFF, 1'b1);  // neither sign nor camera, window wraps
      send_detection(1'b1, 8'd1, 16'h0001, 1'b1);    // one vote for 30

      // camera class inside the sign range, threshold of one
      program_filter(8'd0, 8'h01);
      send_detection(1'b1, 8'd0, 16'h00FF, 1'b1);
      send_detection(1'b1, 8'd1, 16'h0002, 1'b1);
      send_detection(1'b1, 8'd1, 16'h0002, 1'b1);

      // zero threshold still needs a vote
      program_filter(8'hFF, 8'h00);
      send_detection(1'b1, 8'd255, 16'hABCD, 1'b1);
      send_detection(1'b0, 8'd0, 16'h0000, 1'b1);

      // threshold beyond the window, upper data bits set
      program_filter(8'd11, 8'hFF);
      send_detection(1'b1, 8'd5, 16'h4321, 1'b1);
      send_detection(1'b1, 8'd5, 16'h4322, 1'b1);

      // random frames under several settings and idling patterns
      favourite = CLASS_W'($urandom_range(SIGN_CLASSES - 1));
      for (int c = 0; c < RANDOM_CHUNKS; c++) begin
         case (c)
            0: begin cam = 8'd200;                              thr_word = 8'h08; end
            1: begin cam = CLASS_W'($urandom_range(255, 11));   thr_word = 8'h01; end
            2: begin cam = 8'd0;                                thr_word = 8'h02; end
            3: begin cam = CLASS_W'($urandom_range(255, 11));
                     thr_word = {4'($urandom), 4'h4}; end
            4: begin cam = 8'd11;                               thr_word = 8'h03; end
            default: begin
               cam      = CLASS_W'($urandom_range(255, 11));
               thr_word = CSR_W'($urandom_range(8, 1));
            end
         endcase
         if (c < 2) begin
            send_idle_pct = 10;
            recv_idle_pct = 52;
         end else if (c < 4) begin
            send_idle_pct = 52;
            recv_idle_pct = 10;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         program_filter(cam, thr_word);
         chunk_end = items_sent + RANDOM_ITEMS / RANDOM_CHUNKS;
         while (items_sent < chunk_end) begin
            if ($urandom_range(7) == 0) favourite = CLASS_W'($urandom_range(SIGN_CLASSES - 1));
            if ($urandom_range(24) == 0) wait_for_results();
            send_random_frame(favourite);
         end
      end

      // drain and let the block settle
      req_push <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatches == 0)
         $display("** sliding_window_majority_vote_filter_core: PASSED **");
      else
         $display("** sliding_window_majority_vote_filter_core: FAILED **");
      $finish;
   end

endmodule

>>> files.f
sv/swmv_pkg.sv
sv/swmv_front.sv
sv/swmv_fifo.sv
sv/swmv_back.sv
sv/sliding_window_majority_vote_filter_core.sv
tb/sv/sliding_window_majority_vote_filter_core_tb.sv
